// ===== rtl/kst_pkg.sv =====
// Shared types, codes and helpers for the keyed slot table.
`timescale 1ns / 1ps

package kst_pkg;

   localparam int KEY_W      = 32;
   localparam int DEF_ROWS   = 4;
   localparam int DEF_SLOTS  = 8;

   // command codes
   localparam logic [1:0] CMD_STORE  = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LIST   = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_STORED   = 3'd0;
   localparam logic [2:0] STAT_PRESENT  = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_REMOVED  = 3'd3;
   localparam logic [2:0] STAT_NOTFOUND = 3'd4;
   localparam logic [2:0] STAT_LISTING  = 3'd5;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [1:0]       row;
      logic [2:0]       slot;
      logic [KEY_W-1:0] entry_key;
      logic             last;
   } rsp_type;

   // control shared by every cell of the ring
   typedef struct packed {
      logic             shift;
      logic             write;
      logic [KEY_W-1:0] wr_key;
   } cell_ctl_type;

   // clear every byte from the first zero byte onwards
   function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] res;
      logic             run;
      res = '0;
      run = 1'b1;
      for (int b = 0; b < KEY_W / 8; b++) begin
         if (raw[8*b +: 8] == 8'h00) run = 1'b0;
         if (run) res[8*b +: 8] = raw[8*b +: 8];
      end
      return res;
   endfunction

endpackage

// ===== rtl/kst_cell.sv =====
// One entry of the key ring: holds a key, passes it on when the ring turns.
`timescale 1ns / 1ps

module kst_cell
   import kst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic             sel,
   input  logic [KEY_W-1:0] nxt_key,
   output logic [KEY_W-1:0] key
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;

   always_comb begin
      key_in = key_ff;
      if (ctl.shift) begin
         key_in = nxt_key;
      end else if (ctl.write && sel) begin
         key_in = ctl.wr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

// ===== rtl/keyed_slot_table.sv =====
// Top level of the keyed slot table: ring of key cells and its command sequencer.
`timescale 1ns / 1ps
// Store and remove turn the ring past the compare head entry by entry, then write back and
// raise rsp_valid once the result register is free; the sequencer is then back at idle.
// List emits one entry per cycle while rsp_ready stays high, the final one marked last.
// One command is in work at a time; the next is taken once the sequencer is back at idle.
// Synchronous active-high reset empties every entry and drops any pending result.
// Throughput is set by the single compare head at cell zero of the ring.

module keyed_slot_table
   import kst_pkg::*;
#(
   parameter int ROWS  = DEF_ROWS,
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ENTRIES = ROWS * SLOTS;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(ENTRIES - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_LIST   = 4'b1000
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_cnt_ff, idx_cnt_in;
   logic [ROW_W-1:0]  row_cnt_ff, row_cnt_in;
   logic [SLOT_W-1:0] slot_cnt_ff, slot_cnt_in;
   logic              hit_ff, hit_in;
   logic              free_ff, free_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [1:0]        cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [ROW_W-1:0]  hit_row_ff, hit_row_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [ROW_W-1:0]  free_row_ff, free_row_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   rsp_type           rsp_ff, rsp_in;

   // ring
   cell_ctl_type      ctl;
   logic [IDX_W-1:0]  wr_idx;
   logic [KEY_W-1:0]  cell_key [ENTRIES];
   logic [KEY_W-1:0]  head;
   logic              out_free;
   logic              at_last;

   assign head     = cell_key[0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign at_last  = (idx_cnt_ff == IDX_LAST);

   // Each cell takes its upper neighbour's key when the ring turns; the top cell
   // takes the head, so ENTRIES turns bring the ring back to where it started.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      kst_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .sel     (wr_idx == IDX_W'(i)),
         .nxt_key (cell_key[(i + 1) % ENTRIES]),
         .key     (cell_key[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      idx_cnt_in   = idx_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      slot_cnt_in  = slot_cnt_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      hit_idx_in   = hit_idx_ff;
      hit_row_in   = hit_row_ff;
      hit_slot_in  = hit_slot_ff;
      free_idx_in  = free_idx_ff;
      free_row_in  = free_row_ff;
      free_slot_in = free_slot_ff;
      rsp_in       = rsp_ff;
      ctl          = '0;
      wr_idx       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_data.cmd;
               key_in  = normalize_key(req_data.key);
               hit_in  = 1'b0;
               free_in = 1'b0;
               // the unused command code is dropped without a result
               priority if (req_data.cmd == CMD_STORE || req_data.cmd == CMD_REMOVE) begin
                  state_in = ST_SEARCH;
               end else if (req_data.cmd == CMD_LIST) begin
                  state_in = ST_LIST;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SEARCH: begin
            // turn the ring one entry per cycle, note the first match and first hole
            ctl.shift = 1'b1;
            if (head == key_ff && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = idx_cnt_ff;
               hit_row_in  = row_cnt_ff;
               hit_slot_in = slot_cnt_ff;
            end
            if (head == '0 && !free_ff) begin
               free_in      = 1'b1;
               free_idx_in  = idx_cnt_ff;
               free_row_in  = row_cnt_ff;
               free_slot_in = slot_cnt_ff;
            end
            if (at_last) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // hold until the result register is free, then write back and report
            if (out_free) begin
               rsp_in.entry_key = key_ff;
               rsp_in.last      = 1'b1;
               rsp_in.row       = '0;
               rsp_in.slot      = '0;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
               if (cmd_ff == CMD_STORE) begin
                  priority if (hit_ff) begin
                     rsp_in.status = STAT_PRESENT;
                     rsp_in.row    = 2'(hit_row_ff);
                     rsp_in.slot   = 3'(hit_slot_ff);
                  end else if (free_ff) begin
                     rsp_in.status = STAT_STORED;
                     rsp_in.row    = 2'(free_row_ff);
                     rsp_in.slot   = 3'(free_slot_ff);
                     ctl.write     = 1'b1;
                     ctl.wr_key    = key_ff;
                     wr_idx        = free_idx_ff;
                  end else begin
                     rsp_in.status = STAT_FULL;
                  end
               end else begin
                  // an empty key matches a hole; writing zero there changes nothing
                  if (hit_ff) begin
                     rsp_in.status = STAT_REMOVED;
                     rsp_in.row    = 2'(hit_row_ff);
                     rsp_in.slot   = 3'(hit_slot_ff);
                     ctl.write     = 1'b1;
                     ctl.wr_key    = '0;
                     wr_idx        = hit_idx_ff;
                  end else begin
                     rsp_in.status = STAT_NOTFOUND;
                  end
               end
            end
         end

         ST_LIST: begin
            // advance only when the head entry can be handed on
            if (out_free) begin
               ctl.shift        = 1'b1;
               rsp_in.status    = STAT_LISTING;
               rsp_in.row       = 2'(row_cnt_ff);
               rsp_in.slot      = 3'(slot_cnt_ff);
               rsp_in.entry_key = head;
               rsp_in.last      = at_last;
               rsp_valid_in     = 1'b1;
               if (at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // position counters follow the ring; they wrap to zero with it
      if (ctl.shift) begin
         if (at_last) begin
            idx_cnt_in  = '0;
            row_cnt_in  = '0;
            slot_cnt_in = '0;
         end else begin
            idx_cnt_in = idx_cnt_ff + 1'b1;
            if (slot_cnt_ff == SLOT_LAST) begin
               slot_cnt_in = '0;
               row_cnt_in  = row_cnt_ff + 1'b1;
            end else begin
               slot_cnt_in = slot_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         slot_cnt_ff  <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_cnt_ff   <= idx_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         slot_cnt_ff  <= slot_cnt_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      hit_idx_ff   <= hit_idx_in;
      hit_row_ff   <= hit_row_in;
      hit_slot_ff  <= hit_slot_in;
      free_idx_ff  <= free_idx_in;
      free_row_ff  <= free_row_in;
      free_slot_ff <= free_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // the ring must be back in its home alignment whenever a command is taken
   a_home_at_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (idx_cnt_ff == '0 && row_cnt_ff == '0 && slot_cnt_ff == '0))
      else $error("ring position counters not at home while idle");

   // a list transfer starts the walk in the next cycle
   a_list_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd == CMD_LIST) |=> (state_ff == ST_LIST))
      else $error("list command did not start the walk");

   // the final listed entry is the last slot of the last row
   a_list_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_LISTING && rsp_data.last)
         |-> (rsp_data.row == 2'(ROWS - 1) && rsp_data.slot == 3'(SLOTS - 1)))
      else $error("list ended at the wrong entry");

   // store and remove give exactly one result, so it always carries last
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_LISTING) |-> rsp_data.last)
      else $error("single result without last flag");
`endif

endmodule
